// ===== hdl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // radius and arithmetic widths
  localparam int RAD_W   = 11;
  localparam int SQ_W    = 2 * RAD_W;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DEC_W   = 48;
  localparam int ACC_W   = 50;
  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request kind
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // semi-axes carried with a start request
  typedef struct packed {
    logic [RAD_W-1:0] a;
    logic [RAD_W-1:0] b;
  } rad_t;

  // back end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_AA,
    ST_S_BB,
    ST_S_AB,
    ST_S_DEC,
    ST_R1_A,
    ST_R1_B,
    ST_R1_C,
    ST_R1_D,
    ST_R1_E,
    ST_R1_F,
    ST_R1_G,
    ST_SD_A,
    ST_SD_B,
    ST_SD_C,
    ST_SD_D,
    ST_SD_E,
    ST_SD_F,
    ST_R2_A,
    ST_R2_C,
    ST_R2_D,
    ST_R2_E,
    ST_EMIT
  } st_e;

endpackage

`default_nettype wire

// ===== hdl/mer_front.sv =====
// ----------------------------------------------------------------------------
// mer_front
// Accepts requests, classifies them as start or advance and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_front
  import mer_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic                  func_i,
  input  wire logic [COORD_BITS-1:0] center_x_i,
  input  wire logic [COORD_BITS-1:0] center_y_i,
  input  wire logic [RAD_W-1:0]      radius_x_i,
  input  wire logic [RAD_W-1:0]      radius_y_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_pop_i,
  output op_e                        cmd_op_o,
  output rad_t                       cmd_rad_o,
  output logic [COORD_BITS-1:0]      cmd_cx_o,
  output logic [COORD_BITS-1:0]      cmd_cy_o
);

  op_e                   op_q [QUEUE_DEPTH];
  rad_t                  rad_q [QUEUE_DEPTH];
  logic [COORD_BITS-1:0] cx_q [QUEUE_DEPTH];
  logic [COORD_BITS-1:0] cy_q [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  // handshake
  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // pointers, depth is a power of two so they wrap on their own
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage, classify on the way in
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      op_q[wr_ptr_q]  <= func_i ? OP_ADVANCE : OP_START;
      rad_q[wr_ptr_q] <= '{a: radius_x_i, b: radius_y_i};
      cx_q[wr_ptr_q]  <= center_x_i;
      cy_q[wr_ptr_q]  <= center_y_i;
    end
  end

  // head of queue
  assign cmd_op_o  = op_q[rd_ptr_q];
  assign cmd_rad_o = rad_q[rd_ptr_q];
  assign cmd_cx_o  = cx_q[rd_ptr_q];
  assign cmd_cy_o  = cy_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hdl/mer_back.sv =====
// ----------------------------------------------------------------------------
// mer_back
// Carries out start and advance requests: a sequencer around one shared
// 24x24 multiplier steps the two-region midpoint decision and loads the
// result register with the four symmetric pixel coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_back
  import mer_pkg::*;
#(
  parameter int COORD_BITS = 12,
  localparam int OUT_W = COORD_BITS + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_pop_o,
  input  wire op_e                   cmd_op_i,
  input  wire rad_t                  cmd_rad_i,
  input  wire logic [COORD_BITS-1:0] cmd_cx_i,
  input  wire logic [COORD_BITS-1:0] cmd_cy_i,
  output logic                       res_valid_o,
  input  wire logic                  res_pop_i,
  output logic signed [OUT_W-1:0]    x_right_o,
  output logic signed [OUT_W-1:0]    x_left_o,
  output logic signed [OUT_W-1:0]    y_up_o,
  output logic signed [OUT_W-1:0]    y_down_o,
  output logic                       last_o
);

  localparam int SUM_W = ((COORD_BITS > RAD_W) ? COORD_BITS : RAD_W) + 2;

  st_e st_q, st_d;

  logic [RAD_W-1:0]        off_x_q, off_x_d;
  logic [RAD_W-1:0]        off_y_q, off_y_d;
  logic signed [DEC_W-1:0] dec_q, dec_d;
  logic                    r2_q, r2_d;
  logic                    fin_q, fin_d;
  logic [COORD_BITS-1:0]   cx_q, cx_d;
  logic [COORD_BITS-1:0]   cy_q, cy_d;
  logic [RAD_W-1:0]        a_q, a_d;
  logic [RAD_W-1:0]        b_q, b_d;

  logic [SQ_W-1:0]         aa_q, aa_d;
  logic [SQ_W-1:0]         bb_q, bb_d;
  logic [PROD_W-1:0]       tmp_q, tmp_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [MUL_W-1:0]        mul_a, mul_b;

  logic                    res_valid_q, res_valid_d;
  logic [OUT_W-1:0]        xr_q, xr_d, xl_q, xl_d, yu_q, yu_d, yd_q, yd_d;
  logic                    last_q, last_d;

  // signed views of the unsigned terms
  logic signed [DEC_W-1:0] prod_s, tmp_s, aa_s, bb_s, aa4_s;
  logic signed [ACC_W-1:0] prod_x4, seed_full, seed_q4, seed_div;
  logic                    seed_fix;
  logic [RAD_W-1:0]        x_bump;
  logic [RAD_W-1:0]        y_dec;
  logic                    slot_free;
  logic [SUM_W-1:0]        cx_ext, cy_ext, ox_ext, oy_ext;
  logic [SUM_W-1:0]        sum_xr, sum_xl, sum_yu, sum_yd;

  assign prod_s = $signed(prod_q);
  assign tmp_s  = $signed(tmp_q);
  assign aa_s   = $signed({{(DEC_W-SQ_W){1'b0}}, aa_q});
  assign bb_s   = $signed({{(DEC_W-SQ_W){1'b0}}, bb_q});
  assign aa4_s  = $signed({{(DEC_W-SQ_W+2){1'b0}}, aa_q[SQ_W-1:2]});

  // region two seed, divided by four with truncation toward zero
  assign prod_x4   = $signed({{(ACC_W-PROD_W){1'b0}}, prod_q}) <<< 2;
  assign seed_full = acc_q - prod_x4;
  assign seed_q4   = seed_full >>> 2;
  assign seed_fix  = seed_full[ACC_W-1] && (seed_full[1:0] != 2'b00);
  assign seed_div  = seed_q4 + $signed({{(ACC_W-1){1'b0}}, seed_fix});

  // x offset grows with saturation, y offset steps down
  assign x_bump = (off_x_q < RAD_MAX) ? off_x_q + 1'b1 : off_x_q;
  assign y_dec  = off_y_q - 1'b1;

  // pixel coordinates of the current offset
  assign cx_ext = {{(SUM_W-COORD_BITS){1'b0}}, cx_q};
  assign cy_ext = {{(SUM_W-COORD_BITS){1'b0}}, cy_q};
  assign ox_ext = {{(SUM_W-RAD_W){1'b0}}, off_x_q};
  assign oy_ext = {{(SUM_W-RAD_W){1'b0}}, off_y_q};
  assign sum_xr = cx_ext + ox_ext;
  assign sum_xl = cx_ext - ox_ext;
  assign sum_yu = cy_ext + oy_ext;
  assign sum_yd = cy_ext - oy_ext;

  assign slot_free = !res_valid_q || res_pop_i;

  // shared multiplier, product registered every cycle
  assign prod_d = mul_a * mul_b;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_op_i == OP_START) begin
            st_d = ST_S_AA;
          end else if (fin_q) begin
            st_d = ST_EMIT;
          end else if (r2_q) begin
            st_d = ST_R2_A;
          end else begin
            st_d = ST_R1_A;
          end
        end
      end
      ST_S_AA:  st_d = ST_S_BB;
      ST_S_BB:  st_d = ST_S_AB;
      ST_S_AB:  st_d = ST_S_DEC;
      ST_S_DEC: st_d = ST_EMIT;
      ST_R1_A:  st_d = ST_R1_B;
      ST_R1_B:  st_d = ST_R1_C;
      ST_R1_C:  st_d = (tmp_q < prod_q) ? ST_R1_D : ST_SD_A;
      ST_R1_D:  st_d = dec_q[DEC_W-1] ? ST_R1_E : ST_R1_F;
      ST_R1_E:  st_d = ST_EMIT;
      ST_R1_F:  st_d = ST_R1_G;
      ST_R1_G:  st_d = ST_EMIT;
      ST_SD_A:  st_d = ST_SD_B;
      ST_SD_B:  st_d = ST_SD_C;
      ST_SD_C:  st_d = ST_SD_D;
      ST_SD_D:  st_d = ST_SD_E;
      ST_SD_E:  st_d = ST_SD_F;
      ST_SD_F:  st_d = ST_R2_A;
      ST_R2_A:  st_d = (dec_q > 0) ? ST_R2_C : ST_R2_D;
      ST_R2_C:  st_d = ST_EMIT;
      ST_R2_D:  st_d = ST_R2_E;
      ST_R2_E:  st_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          st_d = ST_IDLE;
        end
      end
      default:  st_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    cmd_pop_o   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    dec_d       = dec_q;
    r2_d        = r2_q;
    fin_d       = fin_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    a_d         = a_q;
    b_d         = b_q;
    aa_d        = aa_q;
    bb_d        = bb_q;
    tmp_d       = tmp_q;
    acc_d       = acc_q;
    res_valid_d = res_valid_q && !res_pop_i;
    xr_d        = xr_q;
    xl_d        = xl_q;
    yu_d        = yu_q;
    yd_d        = yd_q;
    last_d      = last_q;
    case (st_q)
      // take the head request, latch the ellipse on start
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_op_i == OP_START) begin
            cx_d = cmd_cx_i;
            cy_d = cmd_cy_i;
            a_d  = cmd_rad_i.a;
            b_d  = cmd_rad_i.b;
          end
        end
      end
      // start: squares of the radii, then the region one seed
      ST_S_AA: begin
        mul_a = MUL_W'(a_q);
        mul_b = MUL_W'(a_q);
      end
      ST_S_BB: begin
        aa_d  = prod_q[SQ_W-1:0];
        mul_a = MUL_W'(b_q);
        mul_b = MUL_W'(b_q);
      end
      ST_S_AB: begin
        bb_d  = prod_q[SQ_W-1:0];
        mul_a = MUL_W'(aa_q);
        mul_b = MUL_W'(b_q);
      end
      ST_S_DEC: begin
        dec_d   = bb_s - prod_s + aa4_s;
        off_x_d = '0;
        off_y_d = b_q;
        r2_d    = 1'b0;
        fin_d   = 1'b0;
      end
      // region one: slope test b*b*x against a*a*y
      ST_R1_A: begin
        mul_a = MUL_W'(bb_q);
        mul_b = MUL_W'(off_x_q);
      end
      ST_R1_B: begin
        tmp_d = prod_q;
        mul_a = MUL_W'(aa_q);
        mul_b = MUL_W'(off_y_q);
      end
      ST_R1_C: begin
        if (tmp_q < prod_q) begin
          off_x_d = x_bump;
        end
      end
      // region one move with the new x
      ST_R1_D: begin
        mul_a = MUL_W'(bb_q);
        mul_b = MUL_W'(off_x_q);
        if (!dec_q[DEC_W-1]) begin
          off_y_d = y_dec;
        end
      end
      ST_R1_E: begin
        dec_d = dec_q + (prod_s <<< 1) + bb_s;
      end
      ST_R1_F: begin
        tmp_d = prod_q;
        mul_a = MUL_W'(aa_q);
        mul_b = MUL_W'(off_y_q);
      end
      ST_R1_G: begin
        dec_d = dec_q + (tmp_s <<< 1) - (prod_s <<< 1) + bb_s;
      end
      // region two seed in quarter units
      ST_SD_A: begin
        mul_a = MUL_W'({off_x_q, 1'b1});
        mul_b = MUL_W'({off_x_q, 1'b1});
      end
      ST_SD_B: begin
        tmp_d = prod_q;
        mul_a = MUL_W'(y_dec);
        mul_b = MUL_W'(y_dec);
      end
      ST_SD_C: begin
        tmp_d = prod_q;
        mul_a = MUL_W'(bb_q);
        mul_b = tmp_q[MUL_W-1:0];
      end
      ST_SD_D: begin
        acc_d = $signed({{(ACC_W-PROD_W){1'b0}}, prod_q});
        mul_a = MUL_W'(aa_q);
        mul_b = MUL_W'(tmp_q[SQ_W-1:0]);
      end
      ST_SD_E: begin
        acc_d = acc_q + prod_x4;
        mul_a = MUL_W'(aa_q);
        mul_b = MUL_W'(bb_q);
      end
      ST_SD_F: begin
        dec_d = $signed(seed_div[DEC_W-1:0]);
        r2_d  = 1'b1;
      end
      // region two move: y down, x on when the decision is not positive
      ST_R2_A: begin
        off_y_d = y_dec;
        mul_a   = MUL_W'(aa_q);
        mul_b   = MUL_W'(y_dec);
        if (!(dec_q > 0)) begin
          off_x_d = x_bump;
        end
      end
      ST_R2_C: begin
        dec_d = dec_q + aa_s - (prod_s <<< 1);
      end
      ST_R2_D: begin
        tmp_d = prod_q;
        mul_a = MUL_W'(bb_q);
        mul_b = MUL_W'(off_x_q);
      end
      ST_R2_E: begin
        dec_d = dec_q + (prod_s <<< 1) - (tmp_s <<< 1) + aa_s;
      end
      // load the result register
      ST_EMIT: begin
        if (slot_free) begin
          res_valid_d = 1'b1;
          xr_d        = sum_xr[OUT_W-1:0];
          xl_d        = sum_xl[OUT_W-1:0];
          yu_d        = sum_yu[OUT_W-1:0];
          yd_d        = sum_yd[OUT_W-1:0];
          last_d      = (off_y_q == '0);
          if (off_y_q == '0) begin
            fin_d = 1'b1;
          end
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // control and ellipse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      off_x_q     <= '0;
      off_y_q     <= '0;
      dec_q       <= '0;
      r2_q        <= 1'b0;
      fin_q       <= 1'b1;
      cx_q        <= '0;
      cy_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      off_x_q     <= off_x_d;
      off_y_q     <= off_y_d;
      dec_q       <= dec_d;
      r2_q        <= r2_d;
      fin_q       <= fin_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      a_q         <= a_d;
      b_q         <= b_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    aa_q   <= aa_d;
    bb_q   <= bb_d;
    tmp_q  <= tmp_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    xr_q   <= xr_d;
    xl_q   <= xl_d;
    yu_q   <= yu_d;
    yd_q   <= yd_d;
    last_q <= last_d;
  end

  assign res_valid_o = res_valid_q;
  assign x_right_o   = $signed(xr_q);
  assign x_left_o    = $signed(xl_q);
  assign y_up_o      = $signed(yu_q);
  assign y_down_o    = $signed(yd_q);
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse rasterizer: one first-quadrant point per request, given
// as the four symmetric pixel coordinates.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------
//   request   push / full          func, center_x, center_y, radius_x/y
//   result    empty / pop          x_right, x_left, y_up, y_down, last
//
// A request for a finished ellipse goes straight to EMIT, a start through
// S_AA..S_DEC, a point through R1 or R2 states and the first point of region
// two via SD_A..SD_F too; the shared 24x24 multiplier is used once per cycle.
// After reset the block is ready at once, with no clearing pass.
// A two-entry request queue keeps accepting while a result waits in the
// output register; the back end halts only when that register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int COORD_BITS = 12,
  localparam int OUT_W = COORD_BITS + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  func_i,
  input  wire logic [COORD_BITS-1:0] center_x_i,
  input  wire logic [COORD_BITS-1:0] center_y_i,
  input  wire logic [RAD_W-1:0]      radius_x_i,
  input  wire logic [RAD_W-1:0]      radius_y_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic signed [OUT_W-1:0]    x_right_o,
  output logic signed [OUT_W-1:0]    x_left_o,
  output logic signed [OUT_W-1:0]    y_up_o,
  output logic signed [OUT_W-1:0]    y_down_o,
  output logic                       last_o
);

  logic                  cmd_valid;
  logic                  cmd_pop;
  op_e                   cmd_op;
  rad_t                  cmd_rad;
  logic [COORD_BITS-1:0] cmd_cx;
  logic [COORD_BITS-1:0] cmd_cy;
  logic                  res_valid;

  // front end: request queue
  mer_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_x_i  (radius_x_i),
    .radius_y_i  (radius_y_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_op_o    (cmd_op),
    .cmd_rad_o   (cmd_rad),
    .cmd_cx_o    (cmd_cx),
    .cmd_cy_o    (cmd_cy)
  );

  // back end: decision sequencer and result register
  mer_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_op_i    (cmd_op),
    .cmd_rad_i   (cmd_rad),
    .cmd_cx_i    (cmd_cx),
    .cmd_cy_i    (cmd_cy),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .x_right_o   (x_right_o),
    .x_left_o    (x_left_o),
    .y_up_o      (y_up_o),
    .y_down_o    (y_down_o),
    .last_o      (last_o)
  );

  assign empty = !res_valid;

`ifndef SYNTH
  // an accepted request is waiting for the back end on the next cycle
  a_push_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> cmd_valid)
    else $error("accepted request missing from queue");

  // back end only takes a request that is there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end popped an empty queue");

  // the last point sits on the centre row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (y_up_o == y_down_o))
    else $error("last point off the centre row");
`endif

endmodule

`default_nettype wire
